// ----- rtl/ftrg_pkg.sv -----
// Frame time resolution governor: shared widths, constants, codes and
// the command/status structs between controller and datapath.
// No dependencies.
package ftrg_pkg;

  localparam int unsigned SeqW     = 64;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ScaleW   = 10;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CntW     = 6;
  localparam int unsigned CoolW    = 5;
  localparam int unsigned FiltW    = 40;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // filter: f += round((x - f) * 13107 / 65536)
  localparam int unsigned AlphaW = 14;
  localparam int unsigned ProdW  = FiltW + AlphaW;
  localparam logic [AlphaW-1:0] AlphaNum  = 14'd13107;
  localparam logic [ProdW-1:0]  RoundHalf = ProdW'(32768);

  // thresholds: f*100 against target*256*102 and target*256*82
  localparam int unsigned CmpW = FiltW + 7;
  localparam logic [6:0]  FiltMul  = 7'd100;
  localparam logic [14:0] OverMul  = 15'd26112;
  localparam logic [14:0] UnderMul = 15'd20992;

  localparam logic [CntW-1:0]  DownSamples = 6'd3;
  localparam logic [CntW-1:0]  UpSamples   = 6'd45;
  localparam logic [CntW-1:0]  CntMax      = 6'd63;
  localparam logic [CoolW-1:0] CoolSamples = 5'd30;

  localparam logic [ScaleW-1:0] ResetMin    = 10'd500;
  localparam logic [ScaleW-1:0] ResetMax    = 10'd1000;
  localparam logic [ScaleW-1:0] ResetStep   = 10'd50;
  localparam logic [TimeW-1:0]  ResetTarget = 32'd16666667;
  localparam logic [ScaleW-1:0] ResetInit   = 10'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_MIN_SCALE  = 3'd1,
    CFG_MAX_SCALE  = 3'd2,
    CFG_SCALE_STEP = 3'd3,
    CFG_TARGET     = 3'd4,
    CFG_INIT_SCALE = 3'd5
  } cfg_idx_e;

  typedef enum logic [StatusW-1:0] {
    ST_REJECT  = 2'd0,
    ST_KEEP    = 2'd1,
    ST_CHANGED = 2'd2
  } status_e;

  typedef struct packed {
    logic ld_in;      // capture request payload
    logic chk;        // validity check, commit seq / first sample
    logic mul;        // filter product
    logic filt;       // filter accumulate
    logic cool;       // cooldown report
    logic scl;        // threshold products
    logic cnt;        // hysteresis counters
    logic step_dn;
    logic step_up;
    logic div_start;  // lattice remainder
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic filt_valid;
    logic cool_active;
    logic go_down;
    logic go_up;
    logic up_low;
    logic div_done;
  } sts_t;

endpackage

// ----- rtl/ftrg_req_if.sv -----
// Frame report request channel: valid/ready plus report fields.
// Depends on ftrg_pkg.
interface ftrg_req_if;
  logic                          valid;
  logic                          ready;
  logic [ftrg_pkg::SeqW-1:0]     submit_seq;
  logic [ftrg_pkg::TimeW-1:0]    frame_time_ns;
  logic [ftrg_pkg::ScaleW-1:0]   frame_scale_milli;

  modport source (output valid, output submit_seq, output frame_time_ns,
                  output frame_scale_milli, input ready);
  modport sink   (input valid, input submit_seq, input frame_time_ns,
                  input frame_scale_milli, output ready);
endinterface

// ----- rtl/ftrg_rsp_if.sv -----
// Governor result channel: valid/ready plus status, scale and change count.
// Depends on ftrg_pkg.
interface ftrg_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ftrg_pkg::StatusW-1:0]  status;
  logic [ftrg_pkg::ScaleW-1:0]   new_scale_milli;
  logic [ftrg_pkg::TimeW-1:0]    transition_total;

  modport source (output valid, output status, output new_scale_milli,
                  output transition_total, input ready);
  modport sink   (input valid, input status, input new_scale_milli,
                  input transition_total, output ready);
endinterface

// ----- rtl/ftrg_ctrl.sv -----
// Governor controller: sequences one request through the datapath and
// owns the request/result handshakes. Depends on ftrg_pkg.
module ftrg_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  ftrg_pkg::sts_t  sts_i,
  output ftrg_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_FILT,
    S_COOL,
    S_CMP,
    S_DECIDE,
    S_DIV,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.chk = 1'b1;
        if (!sts_i.accept) begin
          state_d = S_DONE;
        end else if (sts_i.filt_valid) begin
          state_d = S_MUL;
        end else begin
          state_d = S_COOL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_FILT;
      end
      S_FILT: begin
        cmd_o.filt = 1'b1;
        state_d    = S_COOL;
      end
      S_COOL: begin
        if (sts_i.cool_active) begin
          cmd_o.cool = 1'b1;
          state_d    = S_DONE;
        end else begin
          cmd_o.scl = 1'b1;
          state_d   = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.cnt = 1'b1;
        state_d   = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.go_down) begin
          cmd_o.step_dn = 1'b1;
          state_d       = S_DONE;
        end else if (sts_i.go_up && sts_i.up_low) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else if (sts_i.go_up) begin
          cmd_o.step_up = 1'b1;
          state_d       = S_DONE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.step_up = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        // output register frees up in the same cycle it is taken
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/ftrg_rem.sv -----
// Restoring remainder unit for the scale lattice: one quotient bit per cycle.
// Depends on ftrg_pkg.
module ftrg_rem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ftrg_pkg::ScaleW-1:0] dividend_i,
  input  logic [ftrg_pkg::ScaleW-1:0] divisor_i,
  output logic [ftrg_pkg::ScaleW-1:0] rem_o,
  output logic                        done_o
);

  localparam int unsigned W    = ftrg_pkg::ScaleW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    dvd_q, rem_q, dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [W:0]      trial;
  logic [W:0]      diff;

  assign trial = {rem_q, dvd_q[W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(W);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      dvd_q <= {dvd_q[W-2:0], 1'b0};
      // remainder stays below the divisor, so W bits hold it
      rem_q <= diff[W] ? trial[W-1:0] : diff[W-1:0];
    end
  end

  assign rem_o  = rem_q;
  assign done_o = busy_q && (cnt_q == '0);

endmodule

// ----- rtl/ftrg_dp.sv -----
// Governor datapath: configuration registers, filter, thresholds,
// hysteresis counters, scale stepping and the result register.
// Depends on ftrg_pkg and ftrg_rem.
module ftrg_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ftrg_pkg::cmd_t                cmd_i,
  output ftrg_pkg::sts_t                sts_o,
  input  logic                          cfg_we_i,
  input  logic [ftrg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ftrg_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [ftrg_pkg::SeqW-1:0]     submit_seq_i,
  input  logic [ftrg_pkg::TimeW-1:0]    frame_time_ns_i,
  input  logic [ftrg_pkg::ScaleW-1:0]   frame_scale_milli_i,
  output logic [ftrg_pkg::StatusW-1:0]  status_o,
  output logic [ftrg_pkg::ScaleW-1:0]   new_scale_milli_o,
  output logic [ftrg_pkg::TimeW-1:0]    transition_total_o
);

  localparam int unsigned SW = ftrg_pkg::ScaleW;
  localparam int unsigned FW = ftrg_pkg::FiltW;
  localparam int unsigned PW = ftrg_pkg::ProdW;
  localparam int unsigned CW = ftrg_pkg::CmpW;

  // configuration
  logic                        enable_q;
  logic [SW-1:0]               min_q, max_q, step_q, init_q;
  logic [ftrg_pkg::TimeW-1:0]  target_q;
  // architectural state
  logic [SW-1:0]               cur_q;
  logic [ftrg_pkg::SeqW-1:0]   last_seq_q;
  logic [FW-1:0]               filt_q;
  logic                        fv_q;
  logic [ftrg_pkg::CntW-1:0]   over_q, under_q;
  logic [ftrg_pkg::CoolW-1:0]  cool_q;
  logic [ftrg_pkg::TimeW-1:0]  trans_q;
  // working registers
  logic [ftrg_pkg::SeqW-1:0]   seq_q;
  logic [ftrg_pkg::TimeW-1:0]  ft_q;
  logic [SW-1:0]               fs_q;
  logic [FW-1:0]               diff_q;
  logic                        up_dir_q;
  logic [PW-1:0]               prod_q;
  logic [CW-1:0]               f100_q, over_thr_q, under_thr_q;
  ftrg_pkg::status_e           res_q;
  // result register
  logic [ftrg_pkg::StatusW-1:0] out_status_q;
  logic [SW-1:0]                out_scale_q;
  logic [ftrg_pkg::TimeW-1:0]   out_trans_q;

  logic [FW-1:0]   x;
  logic            near;
  logic            accept;
  logic [SW-1:0]   step_eff;
  logic [SW+1:0]   dn_raw;
  logic [SW-1:0]   dn_val;
  logic [SW:0]     up_next;
  logic [SW-1:0]   up_val;
  logic [SW-1:0]   span;
  logic [SW-1:0]   rem;
  logic            rem_done;
  logic [FW-1:0]   adj;
  logic            en_rise;
  logic            up_low;
  logic [ftrg_pkg::CntW-1:0] over_inc, under_inc;

  assign x = {ft_q, 8'd0};

  // frame scale within one thousandth of the current scale
  assign near = (fs_q == cur_q) ||
                ({1'b0, fs_q} == ({1'b0, cur_q} + 11'd1)) ||
                (({1'b0, fs_q} + 11'd1) == {1'b0, cur_q});

  assign accept = enable_q && (seq_q != '0) && (seq_q > last_seq_q) &&
                  (ft_q != '0) && near;

  assign step_eff = (step_q == '0) ? SW'(1) : step_q;
  assign up_low   = (cur_q <= min_q);

  assign dn_raw = {2'b00, cur_q} - {2'b00, step_eff};
  assign dn_val = ($signed(dn_raw) > $signed({2'b00, min_q})) ? dn_raw[SW-1:0] : min_q;

  assign span = (max_q > min_q) ? (max_q - min_q) : '0;

  // lowest lattice point above the minimum: max - n*step == min + (span mod step)
  always_comb begin
    if (!up_low) begin
      up_next = {1'b0, cur_q} + {1'b0, step_eff};
    end else if (max_q <= min_q) begin
      up_next = {1'b0, max_q};
    end else if (rem == '0) begin
      up_next = {1'b0, min_q} + {1'b0, step_eff};
    end else begin
      up_next = {1'b0, min_q} + {1'b0, rem};
    end
  end
  assign up_val = (up_next < {1'b0, max_q}) ? up_next[SW-1:0] : max_q;

  ftrg_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (span),
    .divisor_i  (step_eff),
    .rem_o      (rem),
    .done_o     (rem_done)
  );

  assign adj       = FW'(prod_q[PW-1:16]);
  assign over_inc  = (over_q  < ftrg_pkg::CntMax) ? (over_q  + 1'b1) : over_q;
  assign under_inc = (under_q < ftrg_pkg::CntMax) ? (under_q + 1'b1) : under_q;
  assign en_rise   = cfg_we_i && (ftrg_pkg::cfg_idx_e'(cfg_idx_i) == ftrg_pkg::CFG_ENABLE) &&
                     cfg_data_i[0] && !enable_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      min_q    <= ftrg_pkg::ResetMin;
      max_q    <= ftrg_pkg::ResetMax;
      step_q   <= ftrg_pkg::ResetStep;
      target_q <= ftrg_pkg::ResetTarget;
      init_q   <= ftrg_pkg::ResetInit;
    end else if (cfg_we_i) begin
      unique case (ftrg_pkg::cfg_idx_e'(cfg_idx_i))
        ftrg_pkg::CFG_ENABLE:     enable_q <= cfg_data_i[0];
        ftrg_pkg::CFG_MIN_SCALE:  min_q    <= cfg_data_i[SW-1:0];
        ftrg_pkg::CFG_MAX_SCALE:  max_q    <= cfg_data_i[SW-1:0];
        ftrg_pkg::CFG_SCALE_STEP: step_q   <= cfg_data_i[SW-1:0];
        ftrg_pkg::CFG_TARGET:     target_q <= cfg_data_i[ftrg_pkg::TimeW-1:0];
        ftrg_pkg::CFG_INIT_SCALE: init_q   <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // governor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= ftrg_pkg::ResetInit;
      last_seq_q <= '0;
      filt_q     <= '0;
      fv_q       <= 1'b0;
      over_q     <= '0;
      under_q    <= '0;
      cool_q     <= '0;
      trans_q    <= '0;
    end else if (en_rise) begin
      cur_q      <= init_q;
      last_seq_q <= '0;
      filt_q     <= '0;
      fv_q       <= 1'b0;
      over_q     <= '0;
      under_q    <= '0;
      cool_q     <= '0;
      trans_q    <= '0;
    end else begin
      if (cmd_i.chk && accept) begin
        last_seq_q <= seq_q;
        if (!fv_q) begin
          filt_q <= x;
          fv_q   <= 1'b1;
        end
      end
      if (cmd_i.filt) begin
        filt_q <= up_dir_q ? (filt_q + adj) : (filt_q - adj);
      end
      if (cmd_i.cool) begin
        cool_q  <= cool_q - 1'b1;
        over_q  <= '0;
        under_q <= '0;
      end
      if (cmd_i.cnt) begin
        if (f100_q > over_thr_q) begin
          over_q  <= over_inc;
          under_q <= '0;
        end else if (f100_q < under_thr_q) begin
          under_q <= under_inc;
          over_q  <= '0;
        end else begin
          over_q  <= '0;
          under_q <= '0;
        end
      end
      if (cmd_i.step_dn || cmd_i.step_up) begin
        cur_q   <= cmd_i.step_dn ? dn_val : up_val;
        over_q  <= '0;
        under_q <= '0;
        cool_q  <= ftrg_pkg::CoolSamples;
        fv_q    <= 1'b0;
        trans_q <= trans_q + 1'b1;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      seq_q <= submit_seq_i;
      ft_q  <= frame_time_ns_i;
      fs_q  <= frame_scale_milli_i;
    end
    if (cmd_i.chk) begin
      up_dir_q <= (x >= filt_q);
      diff_q   <= (x >= filt_q) ? (x - filt_q) : (filt_q - x);
      res_q    <= accept ? ftrg_pkg::ST_KEEP : ftrg_pkg::ST_REJECT;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(diff_q) * PW'(ftrg_pkg::AlphaNum) + ftrg_pkg::RoundHalf;
    end
    if (cmd_i.scl) begin
      f100_q      <= CW'(filt_q) * CW'(ftrg_pkg::FiltMul);
      over_thr_q  <= CW'(target_q) * CW'(ftrg_pkg::OverMul);
      under_thr_q <= CW'(target_q) * CW'(ftrg_pkg::UnderMul);
    end
    if (cmd_i.step_dn || cmd_i.step_up) begin
      res_q <= ftrg_pkg::ST_CHANGED;
    end
    if (cmd_i.out_ld) begin
      out_status_q <= res_q;
      out_scale_q  <= cur_q;
      out_trans_q  <= trans_q;
    end
  end

  assign sts_o.accept      = accept;
  assign sts_o.filt_valid  = fv_q;
  assign sts_o.cool_active = (cool_q != '0);
  assign sts_o.go_down     = (over_q >= ftrg_pkg::DownSamples) && (cur_q > min_q);
  assign sts_o.go_up       = (under_q >= ftrg_pkg::UpSamples) && (cur_q < max_q);
  assign sts_o.up_low      = up_low;
  assign sts_o.div_done    = rem_done;

  assign status_o           = out_status_q;
  assign new_scale_milli_o  = out_scale_q;
  assign transition_total_o = out_trans_q;

endmodule

// ----- rtl/frame_time_resolution_governor.sv -----
// Frame time resolution governor top level: controller, datapath and ports.
// Depends on ftrg_pkg, ftrg_req_if, ftrg_rsp_if, ftrg_ctrl, ftrg_dp.
//
//   channel  dir  handshake        payload
//   req_i    in   valid/ready      submit_seq, frame_time_ns, frame_scale_milli
//   rsp_o    out  valid/ready      status, new_scale_milli, transition_total
//   cfg      in   cfg_we_i only    cfg_idx_i, cfg_data_i
//
// One request at a time: a rejected one goes from the check to the load;
// a first sample skips the filter; a sample in cooldown skips thresholds and
// counters; an up step from the minimum runs the bit-serial lattice remainder unit.
// The result sits in an output register; the next request is taken while
// it waits, and only the final load stalls on an untaken result.
// Reset is asynchronous, active low; no clearing pass is needed.
module frame_time_resolution_governor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ftrg_req_if.sink                      req_i,
  ftrg_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [ftrg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ftrg_pkg::CfgDataW-1:0] cfg_data_i
);

  ftrg_pkg::cmd_t cmd;
  ftrg_pkg::sts_t sts;

  ftrg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ftrg_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .submit_seq_i        (req_i.submit_seq),
    .frame_time_ns_i     (req_i.frame_time_ns),
    .frame_scale_milli_i (req_i.frame_scale_milli),
    .status_o            (rsp_o.status),
    .new_scale_milli_o   (rsp_o.new_scale_milli),
    .transition_total_o  (rsp_o.transition_total)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("second request taken while one is in flight");

  a_no_step_in_cool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.step_dn || cmd.step_up) |-> !sts.cool_active)
    else $error("scale step issued during cooldown");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |=> rsp_o.valid)
    else $error("result load did not raise valid");
`endif

endmodule
